// ----- rtl/joystick_paddle_report_conditioner_core_defines.svh -----
// ----------------------------------------------------------------------------
// Joystick paddle report conditioner: assertion macros
// Concurrent checks clocked on clock, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_PADDLE_REPORT_CONDITIONER_CORE_DEFINES_SVH
`define JOYSTICK_PADDLE_REPORT_CONDITIONER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define JPRC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define JPRC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define JPRC_ASSERT(lbl, prop, msg)
`define JPRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/jprc_pkg.sv -----
// ----------------------------------------------------------------------------
// jprc_pkg
// Shared constants, types and the paddle axis mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package jprc_pkg;

   localparam int PORT_COUNT   = 2;
   localparam int SLOT_W       = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int SWITCH_COUNT = 5;

   // switch positions within a port's row
   localparam int SW_FORWARD  = 0;
   localparam int SW_BACKWARD = 1;
   localparam int SW_LEFT     = 2;
   localparam int SW_RIGHT    = 3;
   localparam int SW_FIRE     = 4;

   localparam int ADC_W  = 10;
   localparam int AXIS_W = 8;
   localparam int THR_W  = 8;
   localparam int CNT_W  = 8;

   localparam logic [THR_W-1:0]  THR_RESET   = 8'd10;
   localparam logic [AXIS_W-1:0] AXIS_CENTRE = 8'd128;
   localparam logic [AXIS_W-1:0] AXIS_MIN    = 8'd0;
   localparam logic [AXIS_W-1:0] AXIS_FULL   = 8'd255;

   // map(a) = 315 - ceil(61380 / a), ceil done as (61380 + a - 1) / a
   localparam int NUM_W = 16;
   localparam logic [NUM_W-1:0] MAP_NUMER  = 16'd61380;
   localparam logic [NUM_W-1:0] MAP_OFFSET = 16'd315;

   // radix-4 restoring divider
   localparam int BITS_PER_STEP = 2;
   localparam int DIV_STEPS     = NUM_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(DIV_STEPS);

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [STEP_W-1:0]  step_type;
   typedef logic [NUM_W-1:0]   num_type;
   typedef logic [ADC_W-1:0]   adc_type;
   typedef logic [AXIS_W-1:0]  axis_type;
   typedef logic [THR_W-1:0]   thr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [SWITCH_COUNT-1:0] sw_vec_type;

   typedef struct packed {
      logic    port_index;
      logic    raw_forward;
      logic    raw_backward;
      logic    raw_left;
      logic    raw_right;
      logic    raw_fire;
      adc_type adc_x;
      adc_type adc_y;
   } req_payload_type;

   typedef struct packed {
      logic     report_port;
      axis_type stick_x;
      axis_type stick_y;
      logic     button_one;
      logic     button_two;
      logic     paddle_present;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;   // take item, debounce, start X division
      logic div_step;  // one radix-4 divider step
      logic save_x;    // keep X quotient, start Y division
      logic load_rsp;  // build report into output register
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } ctl_sts_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIV_X  = 5'b00010,
      ST_SAVE_X = 5'b00100,
      ST_DIV_Y  = 5'b01000,
      ST_DONE   = 5'b10000
   } ctl_state_type;

   function automatic axis_type paddle_map(input adc_type adc, input num_type quot);
      num_type diff;
      diff = MAP_OFFSET - quot;
      if (adc == '0) begin
         return AXIS_FULL;
      end else if (quot >= MAP_OFFSET) begin
         return AXIS_MIN;
      end else begin
         return diff[AXIS_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/jprc_if.sv -----
// ----------------------------------------------------------------------------
// jprc_if
// Scan and report channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface jprc_req_if;
   logic                 valid;
   logic                 ready;
   logic                 port_index;
   logic                 raw_forward;
   logic                 raw_backward;
   logic                 raw_left;
   logic                 raw_right;
   logic                 raw_fire;
   jprc_pkg::adc_type    adc_x;
   jprc_pkg::adc_type    adc_y;

   modport source (
      output valid, port_index, raw_forward, raw_backward, raw_left, raw_right,
             raw_fire, adc_x, adc_y,
      input  ready
   );
   modport sink (
      input  valid, port_index, raw_forward, raw_backward, raw_left, raw_right,
             raw_fire, adc_x, adc_y,
      output ready
   );
endinterface

interface jprc_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 report_port;
   jprc_pkg::axis_type   stick_x;
   jprc_pkg::axis_type   stick_y;
   logic                 button_one;
   logic                 button_two;
   logic                 paddle_present;

   modport source (
      output valid, report_port, stick_x, stick_y, button_one, button_two,
             paddle_present,
      input  ready
   );
   modport sink (
      input  valid, report_port, stick_x, stick_y, button_one, button_two,
             paddle_present,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/jprc_datapath.sv -----
// ----------------------------------------------------------------------------
// jprc_datapath
// Debounce state, shared radix-4 divider, report build and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joystick_paddle_report_conditioner_core_defines.svh"

module jprc_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire jprc_pkg::thr_type         csr_wr_data,
   input  wire jprc_pkg::req_payload_type req_data,
   input  wire jprc_pkg::ctl_cmd_type     cmd,
   output      jprc_pkg::ctl_sts_type     sts,
   input  wire logic                      rsp_ready,
   output      logic                      rsp_valid,
   output      jprc_pkg::rsp_payload_type rsp_data
);

   jprc_pkg::thr_type          thr_ff, thr_in;
   jprc_pkg::sw_vec_type       level_ff [jprc_pkg::PORT_COUNT];
   jprc_pkg::cnt_type          count_ff [jprc_pkg::PORT_COUNT][jprc_pkg::SWITCH_COUNT];

   jprc_pkg::slot_type         slot;
   jprc_pkg::sw_vec_type       raw_vec;
   jprc_pkg::sw_vec_type       row_lvl_in;
   jprc_pkg::cnt_type          row_cnt_in [jprc_pkg::SWITCH_COUNT];

   // item registers
   logic                       port_ff;
   jprc_pkg::sw_vec_type       item_lvl_ff;
   jprc_pkg::adc_type          adc_x_ff;
   jprc_pkg::adc_type          adc_y_ff;
   jprc_pkg::num_type          quot_x_ff;

   // divider: num_ff shifts dividend out and quotient in
   jprc_pkg::num_type          num_ff, num_in;
   jprc_pkg::adc_type          rem_ff, rem_in;
   jprc_pkg::adc_type          den_ff, den_in;
   jprc_pkg::num_type          step_num;
   jprc_pkg::adc_type          step_rem;

   logic                       rsp_valid_ff, rsp_valid_in;
   jprc_pkg::rsp_payload_type  rsp_ff, rsp_in;

   assign slot = (jprc_pkg::PORT_COUNT > 1) ? jprc_pkg::slot_type'(req_data.port_index) : '0;

   always_comb begin
      raw_vec = '0;
      raw_vec[jprc_pkg::SW_FORWARD]  = req_data.raw_forward;
      raw_vec[jprc_pkg::SW_BACKWARD] = req_data.raw_backward;
      raw_vec[jprc_pkg::SW_LEFT]     = req_data.raw_left;
      raw_vec[jprc_pkg::SW_RIGHT]    = req_data.raw_right;
      raw_vec[jprc_pkg::SW_FIRE]     = req_data.raw_fire;
   end

   // pins are active low: pin level equal to state means disagreement
   always_comb begin
      for (int s = 0; s < jprc_pkg::SWITCH_COUNT; s++) begin
         row_lvl_in[s] = level_ff[slot][s];
         row_cnt_in[s] = '0;
         if (raw_vec[s] == level_ff[slot][s]) begin
            if (count_ff[slot][s] > thr_ff) begin
               row_lvl_in[s] = ~level_ff[slot][s];
            end else begin
               row_cnt_in[s] = count_ff[slot][s] + 1'b1;
            end
         end
      end
   end

   assign thr_in = csr_wr_en ? csr_wr_data : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= jprc_pkg::THR_RESET;
         for (int p = 0; p < jprc_pkg::PORT_COUNT; p++) begin
            level_ff[p] <= '0;
            for (int s = 0; s < jprc_pkg::SWITCH_COUNT; s++) begin
               count_ff[p][s] <= '0;
            end
         end
      end else begin
         thr_ff <= thr_in;
         if (cmd.capture) begin
            level_ff[slot] <= row_lvl_in;
            for (int s = 0; s < jprc_pkg::SWITCH_COUNT; s++) begin
               count_ff[slot][s] <= row_cnt_in[s];
            end
         end
      end
   end

   // two dependent restoring steps per cycle
   always_comb begin
      logic [jprc_pkg::ADC_W:0] trial;
      step_num = num_ff;
      step_rem = rem_ff;
      for (int i = 0; i < jprc_pkg::BITS_PER_STEP; i++) begin
         trial    = {step_rem, step_num[jprc_pkg::NUM_W-1]};
         step_num = {step_num[jprc_pkg::NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial       = trial - {1'b0, den_ff};
            step_num[0] = 1'b1;
         end
         step_rem = trial[jprc_pkg::ADC_W-1:0];
      end
   end

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (cmd.capture) begin
         num_in = jprc_pkg::MAP_NUMER + jprc_pkg::num_type'(req_data.adc_x) - 1'b1;
         rem_in = '0;
         den_in = req_data.adc_x;
      end else if (cmd.save_x) begin
         num_in = jprc_pkg::MAP_NUMER + jprc_pkg::num_type'(adc_y_ff) - 1'b1;
         rem_in = '0;
         den_in = adc_y_ff;
      end else if (cmd.div_step) begin
         num_in = step_num;
         rem_in = step_rem;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (cmd.capture) begin
         port_ff     <= req_data.port_index;
         item_lvl_ff <= row_lvl_in;
         adc_x_ff    <= req_data.adc_x;
         adc_y_ff    <= req_data.adc_y;
      end
      if (cmd.save_x) begin
         quot_x_ff <= num_ff;
      end
   end

   // report build; num_ff holds the Y quotient when this is loaded
   always_comb begin
      rsp_in                = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.report_port    = port_ff;
         rsp_in.stick_x        = jprc_pkg::AXIS_CENTRE;
         rsp_in.stick_y        = jprc_pkg::AXIS_CENTRE;
         rsp_in.button_one     = item_lvl_ff[jprc_pkg::SW_FIRE];
         rsp_in.button_two     = 1'b0;
         rsp_in.paddle_present = (adc_x_ff != '0);
         if (item_lvl_ff[jprc_pkg::SW_FORWARD])  rsp_in.stick_y = jprc_pkg::AXIS_MIN;
         if (item_lvl_ff[jprc_pkg::SW_BACKWARD]) rsp_in.stick_y = jprc_pkg::AXIS_FULL;
         if (item_lvl_ff[jprc_pkg::SW_RIGHT])    rsp_in.stick_x = jprc_pkg::AXIS_FULL;
         if (item_lvl_ff[jprc_pkg::SW_LEFT])     rsp_in.stick_x = jprc_pkg::AXIS_MIN;
         if (adc_x_ff != '0) begin
            rsp_in.stick_x    = jprc_pkg::paddle_map(adc_x_ff, quot_x_ff);
            rsp_in.stick_y    = jprc_pkg::paddle_map(adc_y_ff, num_ff);
            rsp_in.button_one = item_lvl_ff[jprc_pkg::SW_FIRE] |
                                item_lvl_ff[jprc_pkg::SW_LEFT];
            rsp_in.button_two = item_lvl_ff[jprc_pkg::SW_RIGHT];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   `JPRC_ASSERT(a_btn_two_needs_paddle, rsp_valid_ff && !rsp_ff.paddle_present |-> !rsp_ff.button_two, "button two without paddle")
   `JPRC_ASSERT_ALWAYS(a_rsp_empty_after_reset, $past(reset) |-> !rsp_valid_ff, "response valid after reset")

endmodule

`default_nettype wire

// ----- rtl/jprc_ctrl.sv -----
// ----------------------------------------------------------------------------
// jprc_ctrl
// Sequencer: capture, X division, Y division, report hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joystick_paddle_report_conditioner_core_defines.svh"

module jprc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire jprc_pkg::ctl_sts_type sts,
   output      jprc_pkg::ctl_cmd_type cmd
);

   jprc_pkg::ctl_state_type state_ff, state_in;
   jprc_pkg::step_type      step_ff, step_in;
   logic                    last_step;

   assign last_step = (step_ff == jprc_pkg::step_type'(jprc_pkg::DIV_STEPS - 1));
   assign req_ready = (state_ff == jprc_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         jprc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               state_in    = jprc_pkg::ST_DIV_X;
            end
         end
         jprc_pkg::ST_DIV_X: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (last_step) begin
               step_in  = '0;
               state_in = jprc_pkg::ST_SAVE_X;
            end
         end
         jprc_pkg::ST_SAVE_X: begin
            cmd.save_x = 1'b1;
            state_in   = jprc_pkg::ST_DIV_Y;
         end
         jprc_pkg::ST_DIV_Y: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (last_step) begin
               step_in  = '0;
               state_in = jprc_pkg::ST_DONE;
            end
         end
         jprc_pkg::ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = jprc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jprc_pkg::ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jprc_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `JPRC_ASSERT(a_load_only_when_free, cmd.load_rsp |-> sts.rsp_free, "report loaded over a pending one")
   `JPRC_ASSERT(a_accept_starts_div, req_valid && req_ready |=> state_ff == jprc_pkg::ST_DIV_X, "accept did not start division")
   `JPRC_ASSERT(a_step_idle_zero, state_ff == jprc_pkg::ST_IDLE |-> step_ff == '0, "step count left over")

endmodule

`default_nettype wire

// ----- rtl/joystick_paddle_report_conditioner_core.sv -----
// ----------------------------------------------------------------------------
// joystick_paddle_report_conditioner_core
// Debounces joystick switches per port and builds a HID stick report,
// with paddle axis mapping from the converter readings.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  req_ch   in   valid/ready     port, 5 active-low switches, adc_x, adc_y
//  rsp_ch   out  valid/ready     port, stick_x, stick_y, buttons, paddle flag
//  csr      in   csr_wr_en       debounce threshold, 8 bits
//
//  Each item is accepted, divided for X and then for Y on the shared
//  radix-4 divider with an operand swap between, and loaded into the output
//  register. The next item is accepted only then, also while a report waits.
//  A stalled report holds the sequencer in its last state until taken.
//  Reset is synchronous; it clears all switch states and counters at once.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_paddle_report_conditioner_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire jprc_pkg::thr_type  csr_wr_data,
   jprc_req_if.sink                req_ch,
   jprc_rsp_if.source              rsp_ch
);

   jprc_pkg::ctl_cmd_type     cmd;
   jprc_pkg::ctl_sts_type     sts;
   jprc_pkg::req_payload_type req_data;
   jprc_pkg::rsp_payload_type rsp_data;
   logic                      req_ready;
   logic                      rsp_valid;

   always_comb begin
      req_data.port_index   = req_ch.port_index;
      req_data.raw_forward  = req_ch.raw_forward;
      req_data.raw_backward = req_ch.raw_backward;
      req_data.raw_left     = req_ch.raw_left;
      req_data.raw_right    = req_ch.raw_right;
      req_data.raw_fire     = req_ch.raw_fire;
      req_data.adc_x        = req_ch.adc_x;
      req_data.adc_y        = req_ch.adc_y;
   end

   jprc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   jprc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.report_port    = rsp_data.report_port;
   assign rsp_ch.stick_x        = rsp_data.stick_x;
   assign rsp_ch.stick_y        = rsp_data.stick_y;
   assign rsp_ch.button_one     = rsp_data.button_one;
   assign rsp_ch.button_two     = rsp_data.button_two;
   assign rsp_ch.paddle_present = rsp_data.paddle_present;

endmodule

`default_nettype wire
